### hdl/assert_macros.svh
// Assertion macros used by the top RTL file of the tag name recognizer.
// No dependencies; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define HNR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define HNR_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define HNR_ASSERT(label, clk, rst_n, prop, msg)
`define HNR_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### hdl/hnr_pkg.sv
// Package for the HTML tag name recognizer: word types, constants and the
// element name table. No dependencies.
`default_nettype none
package hnr_pkg;

  localparam int MAX_NAME_BYTES  = 64;
  localparam int LONGEST_KEYWORD = 10;
  localparam int ELEMENT_COUNT   = 70;
  localparam int CASE_OFFSET     = 32;
  localparam int LEN_W           = $clog2(MAX_NAME_BYTES + 1);
  localparam int WLEN_W          = $clog2(LONGEST_KEYWORD + 1);
  localparam int CHARS_W         = 8 * LONGEST_KEYWORD;
  localparam int ELEM_W          = 7;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

  // Parse class codes.
  localparam logic [1:0] PARSE_NORMAL = 2'd0;
  localparam logic [1:0] PARSE_VOID   = 2'd1;
  localparam logic [1:0] PARSE_RAW    = 2'd2;

  // Display class codes.
  localparam logic [2:0] DISP_INLINE     = 3'd0;
  localparam logic [2:0] DISP_BLOCK      = 3'd1;
  localparam logic [2:0] DISP_INFO       = 3'd2;
  localparam logic [2:0] DISP_TABLE      = 3'd3;
  localparam logic [2:0] DISP_TBODY      = 3'd4;
  localparam logic [2:0] DISP_ROW        = 3'd5;
  localparam logic [2:0] DISP_CELL       = 3'd6;
  localparam logic [2:0] DISP_INLINE_BLK = 3'd7;

  // Content class codes.
  localparam logic [2:0] CONT_PHRASING = 3'd0;
  localparam logic [2:0] CONT_FLOW     = 3'd1;
  localparam logic [2:0] CONT_EMPTY    = 3'd2;
  localparam logic [2:0] CONT_TRANSP   = 3'd3;
  localparam logic [2:0] CONT_TABLE    = 3'd4;
  localparam logic [2:0] CONT_TEXT     = 3'd5;

  // Input word.
  typedef struct packed {
    logic [7:0] character;
    logic       char_present;
    logic       last_char;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [ELEM_W-1:0] element_number;
    logic              name_found;
    logic [2:0]        display_class;
    logic [1:0]        parse_class;
    logic [2:0]        content_class;
    logic              is_void;
    logic              is_raw_text;
    logic              is_block;
  } out_t;

  // A finished name: the first characters kept, newest in the low byte.
  typedef struct packed {
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   len;
  } name_rec_t;

  // Status of the name queue as seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [CHARS_W-1:0] word;
    logic [2:0]         disp;
    logic [1:0]         parse;
    logic [2:0]         content;
  } tag_entry_t;

  // Element table. Names sit right-justified, first character highest.
  localparam tag_entry_t TAG_ROM [0:ELEMENT_COUNT] = '{
    '{80'h0, DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("html"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("head"), DISP_INFO, PARSE_NORMAL, CONT_FLOW},
    '{80'("body"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("div"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("span"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("section"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("header"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("footer"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("nav"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("main"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("article"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("aside"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("p"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("h1"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("h2"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("h3"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("h4"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("h5"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("h6"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("br"), DISP_INLINE, PARSE_VOID, CONT_EMPTY},
    '{80'("hr"), DISP_BLOCK, PARSE_VOID, CONT_EMPTY},
    '{80'("a"), DISP_INLINE, PARSE_NORMAL, CONT_TRANSP},
    '{80'("em"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("strong"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("b"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("i"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("u"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("s"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("code"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("pre"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("blockquote"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("ul"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("ol"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("li"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("dl"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("dt"), DISP_BLOCK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("dd"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("table"), DISP_TABLE, PARSE_NORMAL, CONT_TABLE},
    '{80'("thead"), DISP_TBODY, PARSE_NORMAL, CONT_TABLE},
    '{80'("tbody"), DISP_TBODY, PARSE_NORMAL, CONT_TABLE},
    '{80'("tfoot"), DISP_TBODY, PARSE_NORMAL, CONT_TABLE},
    '{80'("tr"), DISP_ROW, PARSE_NORMAL, CONT_TABLE},
    '{80'("td"), DISP_CELL, PARSE_NORMAL, CONT_FLOW},
    '{80'("th"), DISP_CELL, PARSE_NORMAL, CONT_FLOW},
    '{80'("caption"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("col"), DISP_INFO, PARSE_VOID, CONT_EMPTY},
    '{80'("colgroup"), DISP_INFO, PARSE_NORMAL, CONT_TABLE},
    '{80'("form"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("input"), DISP_INLINE_BLK, PARSE_VOID, CONT_EMPTY},
    '{80'("button"), DISP_INLINE_BLK, PARSE_NORMAL, CONT_PHRASING},
    '{80'("select"), DISP_INLINE_BLK, PARSE_NORMAL, CONT_FLOW},
    '{80'("option"), DISP_INLINE, PARSE_NORMAL, CONT_TEXT},
    '{80'("textarea"), DISP_INLINE_BLK, PARSE_NORMAL, CONT_TEXT},
    '{80'("label"), DISP_INLINE, PARSE_NORMAL, CONT_PHRASING},
    '{80'("img"), DISP_INLINE_BLK, PARSE_VOID, CONT_EMPTY},
    '{80'("video"), DISP_INLINE_BLK, PARSE_NORMAL, CONT_TRANSP},
    '{80'("canvas"), DISP_INLINE_BLK, PARSE_NORMAL, CONT_TRANSP},
    '{80'("source"), DISP_INFO, PARSE_VOID, CONT_EMPTY},
    '{80'("title"), DISP_INFO, PARSE_NORMAL, CONT_TEXT},
    '{80'("meta"), DISP_INFO, PARSE_VOID, CONT_EMPTY},
    '{80'("link"), DISP_INFO, PARSE_VOID, CONT_EMPTY},
    '{80'("style"), DISP_INFO, PARSE_RAW, CONT_TEXT},
    '{80'("script"), DISP_INFO, PARSE_RAW, CONT_TEXT},
    '{80'("base"), DISP_INFO, PARSE_VOID, CONT_EMPTY},
    '{80'("template"), DISP_BLOCK, PARSE_NORMAL, CONT_FLOW},
    '{80'("slot"), DISP_INLINE, PARSE_NORMAL, CONT_TRANSP},
    '{80'("area"), DISP_INLINE, PARSE_VOID, CONT_EMPTY},
    '{80'("embed"), DISP_INLINE_BLK, PARSE_VOID, CONT_EMPTY},
    '{80'("track"), DISP_INFO, PARSE_VOID, CONT_EMPTY},
    '{80'("wbr"), DISP_INLINE, PARSE_VOID, CONT_EMPTY}
  };

  // Number of characters in a table name: its nonzero bytes.
  function automatic logic [WLEN_W-1:0] word_len(input logic [CHARS_W-1:0] w);
    logic [WLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < LONGEST_KEYWORD; i++) begin
      if (w[8*i +: 8] != 8'h00) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### hdl/hnr_front.sv
// Front part: takes characters, folds case, keeps the name and its length,
// and pushes a finished name into the queue. Depends on hnr_pkg.
`default_nettype none
module hnr_front import hnr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_t       in_data,
  input  wire q_status_t q_stat,
  output logic           push,
  output name_rec_t      push_rec
);

  logic [CHARS_W-1:0] chars_r, chars_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [7:0]         folded;
  logic               accept;
  name_rec_t          upd;

  // Hold the source only while the queue has no room.
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && in_data.last_char;
  assign push_rec = upd;

  // Fold upper case letters to lower case.
  always_comb begin
    folded = in_data.character;
    if (in_data.character >= CHAR_UPPER_A && in_data.character <= CHAR_UPPER_Z) begin
      folded = in_data.character + 8'(CASE_OFFSET);
    end
  end

  // Name state after this word's character is taken.
  always_comb begin
    upd.chars = chars_r;
    upd.len   = len_r;
    if (in_data.char_present) begin
      if (len_r < LEN_W'(LONGEST_KEYWORD)) begin
        upd.chars = {chars_r[CHARS_W-9:0], folded};
      end
      if (len_r < LEN_W'(MAX_NAME_BYTES)) begin
        upd.len = len_r + 1'b1;
      end
    end
  end

  // A finished name clears the state for the next one.
  always_comb begin
    chars_nxt = chars_r;
    len_nxt   = len_r;
    if (accept) begin
      if (in_data.last_char) begin
        chars_nxt = '0;
        len_nxt   = '0;
      end else begin
        chars_nxt = upd.chars;
        len_nxt   = upd.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r <= '0;
      len_r   <= '0;
    end else begin
      chars_r <= chars_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/hnr_queue.sv
// Two-entry queue of finished names between the front and back parts.
// Depends on hnr_pkg.
`default_nettype none
module hnr_queue import hnr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire name_rec_t push_rec,
  input  wire logic      pop,
  output name_rec_t      head_rec,
  output q_status_t      q_stat
);

  name_rec_t  mem [0:1];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign head_rec     = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

endmodule
`default_nettype wire

### hdl/hnr_back.sv
// Back part: compares the queued name against the element table in parallel
// and holds the result word in an output register. Depends on hnr_pkg.
`default_nettype none
module hnr_back import hnr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire name_rec_t head_rec,
  input  wire q_status_t q_stat,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_t           out_data
);

  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;
  out_t              res;
  logic [ELEM_W-1:0] id;
  logic              len_ok;
  tag_entry_t        ent;

  // Take a name when the output register is free or being emptied.
  assign pop       = !q_stat.empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Exact match over table entries 1 to ELEMENT_COUNT; names are distinct.
  always_comb begin
    len_ok = (head_rec.len != '0) && (head_rec.len < LEN_W'(MAX_NAME_BYTES))
             && (head_rec.len <= LEN_W'(LONGEST_KEYWORD));
    id = '0;
    for (int k = 1; k <= ELEMENT_COUNT; k++) begin
      if (len_ok && head_rec.chars == TAG_ROM[k].word
          && head_rec.len == LEN_W'(word_len(TAG_ROM[k].word))) begin
        id = ELEM_W'(k);
      end
    end
  end

  // Table fields and derived flags; entry zero is all zero.
  always_comb begin
    ent                = TAG_ROM[id];
    res.element_number = id;
    res.name_found     = (id != '0);
    res.display_class  = ent.disp;
    res.parse_class    = ent.parse;
    res.content_class  = ent.content;
    res.is_void        = (ent.parse == PARSE_VOID);
    res.is_raw_text    = (ent.parse == PARSE_RAW);
    res.is_block       = (ent.disp >= DISP_BLOCK) && (ent.disp != DISP_INFO)
                         && (ent.disp <= DISP_CELL);
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

endmodule
`default_nettype wire

### hdl/html_tag_name_recognizer_unit.sv
// HTML tag name recognizer. A name arrives one character word per cycle
// while the input is not stalled, and is ended by a word with last_char set.
// The finished name is registered in the queue and its result word then in
// the output register. The unit takes one input word every cycle unless
// stalled: names are held in a two-entry queue, so the input stalls only
// when two finished names wait behind a stalled output.
// Depends on hnr_pkg, hnr_front, hnr_queue, hnr_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module html_tag_name_recognizer_unit import hnr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic      push;
  logic      pop;
  name_rec_t push_rec;
  name_rec_t head_rec;
  q_status_t q_stat;
  logic      found_agrees;
  logic      unknown_clean;

  // Character intake.
  hnr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  // Finished names waiting for lookup.
  hnr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  // Table lookup and result word.
  hnr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_rec  (head_rec),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Consistency terms of the result word.
  assign found_agrees  = (out_data.name_found == (out_data.element_number != '0));
  assign unknown_clean = out_data.name_found ||
                         ((out_data.display_class == '0) && (out_data.parse_class == '0) &&
                          (out_data.content_class == '0) && !out_data.is_block);

  // A name must never be written into a full queue.
  `HNR_NEVER(a_no_push_full, clk, rst_n, push && q_stat.full, "name pushed into full queue")
  // A pop never comes from an empty queue.
  `HNR_NEVER(a_no_pop_empty, clk, rst_n, pop && q_stat.empty, "pop from empty queue")
  // The found flag agrees with the element number.
  `HNR_ASSERT(a_found_id, clk, rst_n, out_valid |-> found_agrees, "found flag disagrees")
  // An unknown name carries all-zero classes and a clear block flag.
  `HNR_ASSERT(a_unknown_zero, clk, rst_n, out_valid |-> unknown_clean, "unknown name has classes")

endmodule
`default_nettype wire
